### hdl/bezier_curve_flattener_assert.svh
// Assertion macros for the curve flattener.
`ifndef BEZIER_CURVE_FLATTENER_ASSERT_SVH
`define BEZIER_CURVE_FLATTENER_ASSERT_SVH

// Same-cycle implication, sampled on the block clock.
`define BCF_ASSERT_SAME(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("curve flattener check failed");

// Next-cycle implication, sampled on the block clock.
`define BCF_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("curve flattener check failed");

`endif

### hdl/bcf_pkg.sv
package bcf_pkg;

   // fixed field widths
   localparam int SEG_BITS = 12;
   localparam int OUT_BITS = 12;
   localparam int IN_BITS  = 12;
   // fraction bits of the length and the segment size
   localparam int LEN_FRAC = 8;
   // left shift of the squared leg before the root (two times LEN_FRAC)
   localparam int LEG_PAD  = 16;

   // commands from the sequencer to the datapath
   typedef struct packed {
      logic load;
      logic leg_load;
      logic leg_step;
      logic leg_add;
      logic div_step;
      logic clamp;
      logic den_sq;
      logic den_cube;
      logic wt_sq;
      logic wt_mul;
      logic acc_step;
      logic vdiv_step;
      logic emit;
   } cmd_type;

   // status back to the sequencer
   typedef struct packed {
      logic root_last;
      logic leg_last;
      logic div_go;
      logic acc_last;
      logic vdiv_last;
      logic k_last;
   } sts_type;

endpackage

### hdl/bcf_datapath.sv
module bcf_datapath #(
   parameter int MAX_SEGMENTS = 32,
   parameter int COORD_BITS   = 12
) (
   input  logic                          clock,
   input  logic                          reset,
   input  bcf_pkg::cmd_type              cmd,
   output bcf_pkg::sts_type              sts,
   input  logic                          req_degree,
   input  logic [bcf_pkg::IN_BITS-1:0]   req_start_x,
   input  logic [bcf_pkg::IN_BITS-1:0]   req_start_y,
   input  logic [bcf_pkg::IN_BITS-1:0]   req_ctrl_a_x,
   input  logic [bcf_pkg::IN_BITS-1:0]   req_ctrl_a_y,
   input  logic [bcf_pkg::IN_BITS-1:0]   req_ctrl_b_x,
   input  logic [bcf_pkg::IN_BITS-1:0]   req_ctrl_b_y,
   input  logic [bcf_pkg::IN_BITS-1:0]   req_end_x,
   input  logic [bcf_pkg::IN_BITS-1:0]   req_end_y,
   input  logic                          csr_write_enable,
   input  logic [bcf_pkg::SEG_BITS-1:0]  csr_write_data,
   output logic                          rsp_valid,
   output logic [bcf_pkg::OUT_BITS-1:0]  rsp_vertex_x,
   output logic [bcf_pkg::OUT_BITS-1:0]  rsp_vertex_y,
   output logic                          rsp_last_vertex,
   output logic                          rsp_count_clamped
);

   localparam int CB   = COORD_BITS;
   localparam int NB   = $clog2(MAX_SEGMENTS + 1);
   localparam int QW   = $clog2(MAX_SEGMENTS + 2);
   localparam int NB2  = 2 * NB;
   localparam int RB   = CB + 9;
   localparam int RADW = 2 * RB;
   localparam int RMW  = RB + 2;
   localparam int SQW  = 2 * CB + 1;
   localparam int LW   = RB + 3;
   localparam int WB   = 3 * NB;
   localparam int AW   = CB + WB;
   localparam int CW   = $clog2(RB + 1);
   localparam int DW   = bcf_pkg::SEG_BITS + bcf_pkg::LEN_FRAC;
   localparam int IW   = bcf_pkg::IN_BITS;
   localparam int OW   = bcf_pkg::OUT_BITS;

   // points, packed four to a vector
   logic [4*CB-1:0]  px_ff, px_in, py_ff, py_in;
   logic             cubic_ff, cubic_in;
   logic [bcf_pkg::SEG_BITS-1:0] seg_ff, seg_in;
   // leg length unit
   logic [1:0]       leg_ff, leg_in;
   logic [RADW-1:0]  rad_ff, rad_in;
   logic [RMW-1:0]   rem_ff, rem_in;
   logic [RB-1:0]    root_ff, root_in;
   logic [LW-1:0]    len_ff, len_in;
   logic [CW-1:0]    cnt_ff, cnt_in;
   // segment count
   logic [QW-1:0]    q_ff, q_in;
   logic [NB-1:0]    n_ff, n_in;
   logic             clamp_ff, clamp_in;
   logic [NB2-1:0]   nn_ff, nn_in;
   logic [WB-1:0]    den_ff, den_in;
   // vertex evaluation
   logic [NB-1:0]    k_ff, k_in;
   logic [NB2-1:0]   kk_ff, kk_in, uu_ff, uu_in;
   logic [4*WB-1:0]  w_ff, w_in;
   logic [AW-1:0]    accx_ff, accx_in, accy_ff, accy_in;
   logic [CB-1:0]    qx_ff, qx_in, qy_ff, qy_in;
   // result beat
   logic             valid_ff, valid_in;
   logic [OW-1:0]    vx_ff, vx_in, vy_ff, vy_in;
   logic             last_ff, last_in;
   logic             cl_ff, cl_in;

   // combinational helpers
   logic [1:0]       b_idx;
   logic [CB-1:0]    ax, ay, bx, by, dx, dy;
   logic [2*CB-1:0]  dxx, dyy;
   logic [SQW-1:0]   sq;
   logic [RMW-1:0]   rem_sh, trial;
   logic [bcf_pkg::SEG_BITS-1:0] seg_eff;
   logic [DW-1:0]    dsz;
   logic [LW-1:0]    dsz_l;
   logic [NB-1:0]    u;
   logic [1:0]       t_idx;
   logic [CW-1:0]    bitpos;
   logic [AW-1:0]    dsh;
   logic             gex, gey;

   // coordinate masking to COORD_BITS
   function automatic logic [CB-1:0] fit(input logic [IW-1:0] v);
      logic [CB+IW-1:0] t;
      t = {{CB{1'b0}}, v};
      return t[CB-1:0];
   endfunction

   function automatic logic [OW-1:0] out_fit(input logic [CB-1:0] v);
      logic [CB+OW-1:0] t;
      t = {{OW{1'b0}}, v};
      return t[OW-1:0];
   endfunction

   // leg endpoints and squared distance
   always_comb begin
      b_idx = leg_ff + 2'd1;
      ax = px_ff[leg_ff*CB +: CB];
      ay = py_ff[leg_ff*CB +: CB];
      bx = px_ff[b_idx*CB +: CB];
      by = py_ff[b_idx*CB +: CB];
      dx = (ax > bx) ? ax - bx : bx - ax;
      dy = (ay > by) ? ay - by : by - ay;
      dxx = dx * dx;
      dyy = dy * dy;
      sq = {1'b0, dxx} + {1'b0, dyy};
      rem_sh = {rem_ff[RB-1:0], rad_ff[RADW-1 -: 2]};
      trial = {root_ff, 2'b01};
      seg_eff = (seg_ff == '0) ? bcf_pkg::SEG_BITS'(1) : seg_ff;
      dsz = {seg_eff, {bcf_pkg::LEN_FRAC{1'b0}}};
      dsz_l = LW'(dsz);
      u = n_ff - k_ff;
      t_idx = cnt_ff[1:0];
      bitpos = CW'(CB - 1) - cnt_ff;
      dsh = AW'(den_ff) << bitpos;
      gex = accx_ff >= dsh;
      gey = accy_ff >= dsh;
   end

   // status
   always_comb begin
      sts.root_last = cnt_ff == CW'(RB - 1);
      sts.leg_last = leg_ff == (cubic_ff ? 2'd2 : 2'd1);
      sts.div_go = (len_ff >= dsz_l) && (q_ff <= QW'(MAX_SEGMENTS));
      sts.acc_last = t_idx == 2'd3;
      sts.vdiv_last = cnt_ff == CW'(CB - 1);
      sts.k_last = k_ff == n_ff;
   end

   // next-state of the datapath
   always_comb begin
      px_in = px_ff;
      py_in = py_ff;
      cubic_in = cubic_ff;
      seg_in = csr_write_enable ? csr_write_data : seg_ff;
      leg_in = leg_ff;
      rad_in = rad_ff;
      rem_in = rem_ff;
      root_in = root_ff;
      len_in = len_ff;
      cnt_in = cnt_ff;
      q_in = q_ff;
      n_in = n_ff;
      clamp_in = clamp_ff;
      nn_in = nn_ff;
      den_in = den_ff;
      k_in = k_ff;
      kk_in = kk_ff;
      uu_in = uu_ff;
      w_in = w_ff;
      accx_in = accx_ff;
      accy_in = accy_ff;
      qx_in = qx_ff;
      qy_in = qy_ff;
      valid_in = 1'b0;
      vx_in = vx_ff;
      vy_in = vy_ff;
      last_in = last_ff;
      cl_in = cl_ff;

      // capture the curve; a quadratic takes the end point as its third point
      if (cmd.load) begin
         px_in = {fit(req_end_x), req_degree ? fit(req_ctrl_b_x) : fit(req_end_x),
                  fit(req_ctrl_a_x), fit(req_start_x)};
         py_in = {fit(req_end_y), req_degree ? fit(req_ctrl_b_y) : fit(req_end_y),
                  fit(req_ctrl_a_y), fit(req_start_y)};
         cubic_in = req_degree;
         len_in = '0;
         leg_in = '0;
         q_in = '0;
      end

      // start one leg root
      if (cmd.leg_load) begin
         rad_in = RADW'({sq, {bcf_pkg::LEG_PAD{1'b0}}});
         rem_in = '0;
         root_in = '0;
         cnt_in = '0;
      end

      // one root digit per cycle
      if (cmd.leg_step) begin
         if (rem_sh >= trial) begin
            rem_in = rem_sh - trial;
            root_in = {root_ff[RB-2:0], 1'b1};
         end else begin
            rem_in = rem_sh;
            root_in = {root_ff[RB-2:0], 1'b0};
         end
         rad_in = {rad_ff[RADW-3:0], 2'b00};
         cnt_in = cnt_ff + CW'(1);
      end

      if (cmd.leg_add) begin
         len_in = len_ff + LW'(root_ff);
         leg_in = leg_ff + 2'd1;
      end

      // count segments by repeated subtraction, stopping past the maximum
      if (cmd.div_step) begin
         len_in = len_ff - dsz_l;
         q_in = q_ff + QW'(1);
      end

      if (cmd.clamp) begin
         if (q_ff == '0) begin
            n_in = NB'(1);
            clamp_in = 1'b1;
         end else if (q_ff > QW'(MAX_SEGMENTS)) begin
            n_in = NB'(MAX_SEGMENTS);
            clamp_in = 1'b1;
         end else begin
            n_in = NB'(q_ff);
            clamp_in = 1'b0;
         end
         k_in = '0;
      end

      if (cmd.den_sq) begin
         nn_in = NB2'(n_ff) * NB2'(n_ff);
      end

      if (cmd.den_cube) begin
         den_in = cubic_ff ? WB'(nn_ff) * WB'(n_ff) : WB'(nn_ff);
      end

      // Bernstein weights, squares first
      if (cmd.wt_sq) begin
         kk_in = NB2'(k_ff) * NB2'(k_ff);
         uu_in = NB2'(u) * NB2'(u);
      end

      if (cmd.wt_mul) begin
         if (cubic_ff) begin
            w_in = {WB'(kk_ff) * WB'(k_ff),
                    WB'(3) * (WB'(kk_ff) * WB'(u)),
                    WB'(3) * (WB'(uu_ff) * WB'(k_ff)),
                    WB'(uu_ff) * WB'(u)};
         end else begin
            w_in = {WB'(0),
                    WB'(kk_ff),
                    WB'(2) * (WB'(k_ff) * WB'(u)),
                    WB'(uu_ff)};
         end
         accx_in = '0;
         accy_in = '0;
         cnt_in = '0;
      end

      // weighted sum, one control point per cycle
      if (cmd.acc_step) begin
         accx_in = accx_ff + AW'(px_ff[t_idx*CB +: CB]) * AW'(w_ff[t_idx*WB +: WB]);
         accy_in = accy_ff + AW'(py_ff[t_idx*CB +: CB]) * AW'(w_ff[t_idx*WB +: WB]);
         cnt_in = sts.acc_last ? '0 : cnt_ff + CW'(1);
      end

      // divide both sums by the denominator, one quotient bit per cycle
      if (cmd.vdiv_step) begin
         if (gex) accx_in = accx_ff - dsh;
         if (gey) accy_in = accy_ff - dsh;
         qx_in = {qx_ff[CB-2:0], gex};
         qy_in = {qy_ff[CB-2:0], gey};
         cnt_in = sts.vdiv_last ? '0 : cnt_ff + CW'(1);
      end

      if (cmd.emit) begin
         valid_in = 1'b1;
         vx_in = out_fit(qx_ff);
         vy_in = out_fit(qy_ff);
         last_in = sts.k_last;
         cl_in = clamp_ff;
         k_in = k_ff + NB'(1);
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         seg_ff <= bcf_pkg::SEG_BITS'(4);
         valid_ff <= 1'b0;
      end else begin
         seg_ff <= seg_in;
         valid_ff <= valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      px_ff <= px_in;
      py_ff <= py_in;
      cubic_ff <= cubic_in;
      leg_ff <= leg_in;
      rad_ff <= rad_in;
      rem_ff <= rem_in;
      root_ff <= root_in;
      len_ff <= len_in;
      cnt_ff <= cnt_in;
      q_ff <= q_in;
      n_ff <= n_in;
      clamp_ff <= clamp_in;
      nn_ff <= nn_in;
      den_ff <= den_in;
      k_ff <= k_in;
      kk_ff <= kk_in;
      uu_ff <= uu_in;
      w_ff <= w_in;
      accx_ff <= accx_in;
      accy_ff <= accy_in;
      qx_ff <= qx_in;
      qy_ff <= qy_in;
      vx_ff <= vx_in;
      vy_ff <= vy_in;
      last_ff <= last_in;
      cl_ff <= cl_in;
   end

   assign rsp_valid = valid_ff;
   assign rsp_vertex_x = vx_ff;
   assign rsp_vertex_y = vy_ff;
   assign rsp_last_vertex = last_ff;
   assign rsp_count_clamped = cl_ff;

endmodule

### hdl/bcf_control.sv
module bcf_control (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   output bcf_pkg::cmd_type  cmd,
   input  bcf_pkg::sts_type  sts
);

   localparam logic [3:0] S_IDLE     = 4'd0;
   localparam logic [3:0] S_LEG_LOAD = 4'd1;
   localparam logic [3:0] S_LEG_STEP = 4'd2;
   localparam logic [3:0] S_LEG_ADD  = 4'd3;
   localparam logic [3:0] S_DIV      = 4'd4;
   localparam logic [3:0] S_CLAMP    = 4'd5;
   localparam logic [3:0] S_DEN_SQ   = 4'd6;
   localparam logic [3:0] S_DEN_CUBE = 4'd7;
   localparam logic [3:0] S_WT_SQ    = 4'd8;
   localparam logic [3:0] S_WT_MUL   = 4'd9;
   localparam logic [3:0] S_ACC      = 4'd10;
   localparam logic [3:0] S_VDIV     = 4'd11;
   localparam logic [3:0] S_EMIT     = 4'd12;

   logic [3:0] state_ff, state_in;

   // sequencing
   always_comb begin
      state_in = state_ff;
      cmd = '0;
      case (state_ff)
         S_IDLE: begin
            if (start) begin
               cmd.load = 1'b1;
               state_in = S_LEG_LOAD;
            end
         end
         S_LEG_LOAD: begin
            cmd.leg_load = 1'b1;
            state_in = S_LEG_STEP;
         end
         S_LEG_STEP: begin
            cmd.leg_step = 1'b1;
            if (sts.root_last) state_in = S_LEG_ADD;
         end
         S_LEG_ADD: begin
            cmd.leg_add = 1'b1;
            state_in = sts.leg_last ? S_DIV : S_LEG_LOAD;
         end
         S_DIV: begin
            if (sts.div_go) cmd.div_step = 1'b1;
            else state_in = S_CLAMP;
         end
         S_CLAMP: begin
            cmd.clamp = 1'b1;
            state_in = S_DEN_SQ;
         end
         S_DEN_SQ: begin
            cmd.den_sq = 1'b1;
            state_in = S_DEN_CUBE;
         end
         S_DEN_CUBE: begin
            cmd.den_cube = 1'b1;
            state_in = S_WT_SQ;
         end
         S_WT_SQ: begin
            cmd.wt_sq = 1'b1;
            state_in = S_WT_MUL;
         end
         S_WT_MUL: begin
            cmd.wt_mul = 1'b1;
            state_in = S_ACC;
         end
         S_ACC: begin
            cmd.acc_step = 1'b1;
            if (sts.acc_last) state_in = S_VDIV;
         end
         S_VDIV: begin
            cmd.vdiv_step = 1'b1;
            if (sts.vdiv_last) state_in = S_EMIT;
         end
         S_EMIT: begin
            cmd.emit = 1'b1;
            state_in = sts.k_last ? S_IDLE : S_WT_SQ;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) state_ff <= S_IDLE;
      else state_ff <= state_in;
   end

   assign busy = state_ff != S_IDLE;

endmodule

### hdl/bezier_curve_flattener.sv
// Flattens one quadratic or cubic Bezier curve into n+1 polyline vertices, n being the
// control polygon length over segment_length, held to 1..MAX_SEGMENTS. A curve is taken
// when start is high and busy is low; busy stays high until the last vertex beat is shown.
// Each vertex is on the rsp_ ports for exactly one cycle with rsp_valid high and cannot be
// held off, so the receiver must take every beat as it comes. The work is done by the shared
// bit-serial units in order: one square root per leg (2 legs quadratic, 3 cubic), the
// segment count by one subtraction per whole segment, stopping once it passes MAX_SEGMENTS,
// the clamp and the denominator setup, then per vertex the weights, four multiply-adds and
// a division at one quotient bit per cycle. Write segment_length only while busy is low.
module bezier_curve_flattener #(
   parameter int MAX_SEGMENTS = 32,
   parameter int COORD_BITS   = 12
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   output logic                          busy,
   input  logic                          req_degree,
   input  logic [bcf_pkg::IN_BITS-1:0]   req_start_x,
   input  logic [bcf_pkg::IN_BITS-1:0]   req_start_y,
   input  logic [bcf_pkg::IN_BITS-1:0]   req_ctrl_a_x,
   input  logic [bcf_pkg::IN_BITS-1:0]   req_ctrl_a_y,
   input  logic [bcf_pkg::IN_BITS-1:0]   req_ctrl_b_x,
   input  logic [bcf_pkg::IN_BITS-1:0]   req_ctrl_b_y,
   input  logic [bcf_pkg::IN_BITS-1:0]   req_end_x,
   input  logic [bcf_pkg::IN_BITS-1:0]   req_end_y,
   input  logic                          csr_write_enable,
   input  logic [bcf_pkg::SEG_BITS-1:0]  csr_write_data,
   output logic                          rsp_valid,
   output logic [bcf_pkg::OUT_BITS-1:0]  rsp_vertex_x,
   output logic [bcf_pkg::OUT_BITS-1:0]  rsp_vertex_y,
   output logic                          rsp_last_vertex,
   output logic                          rsp_count_clamped
);

   bcf_pkg::cmd_type cmd;
   bcf_pkg::sts_type sts;

   bcf_control u_control (
      .clock (clock),
      .reset (reset),
      .start (start),
      .busy  (busy),
      .cmd   (cmd),
      .sts   (sts)
   );

   bcf_datapath #(
      .MAX_SEGMENTS (MAX_SEGMENTS),
      .COORD_BITS   (COORD_BITS)
   ) u_datapath (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .sts               (sts),
      .req_degree        (req_degree),
      .req_start_x       (req_start_x),
      .req_start_y       (req_start_y),
      .req_ctrl_a_x      (req_ctrl_a_x),
      .req_ctrl_a_y      (req_ctrl_a_y),
      .req_ctrl_b_x      (req_ctrl_b_x),
      .req_ctrl_b_y      (req_ctrl_b_y),
      .req_end_x         (req_end_x),
      .req_end_y         (req_end_y),
      .csr_write_enable  (csr_write_enable),
      .csr_write_data    (csr_write_data),
      .rsp_valid         (rsp_valid),
      .rsp_vertex_x      (rsp_vertex_x),
      .rsp_vertex_y      (rsp_vertex_y),
      .rsp_last_vertex   (rsp_last_vertex),
      .rsp_count_clamped (rsp_count_clamped)
   );

   `include "bezier_curve_flattener_assert.svh"

   // the final vertex beat coincides with the return to idle
   `BCF_ASSERT_SAME(a_last_idle, rsp_valid && rsp_last_vertex, !busy)
   // any other vertex beat leaves the block busy
   `BCF_ASSERT_SAME(a_mid_busy, rsp_valid && !rsp_last_vertex, busy)
   // an accepted curve never yields a beat on the next cycle
   `BCF_ASSERT_NEXT(a_accept, start && !busy, busy && !rsp_valid)
   // vertex beats are never back to back
   `BCF_ASSERT_NEXT(a_gap, rsp_valid, !rsp_valid)

endmodule

### sim/bezier_curve_flattener_tb.sv
`timescale 1ns / 1ps

module bezier_curve_flattener_tb;

   localparam int MAX_SEG    = 32;
   localparam int SETTLE_CYC = 1000;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic start = 1'b0;
   logic busy;
   logic req_degree = 1'b0;
   logic [bcf_pkg::IN_BITS-1:0] req_start_x = '0, req_start_y = '0;
   logic [bcf_pkg::IN_BITS-1:0] req_ctrl_a_x = '0, req_ctrl_a_y = '0;
   logic [bcf_pkg::IN_BITS-1:0] req_ctrl_b_x = '0, req_ctrl_b_y = '0;
   logic [bcf_pkg::IN_BITS-1:0] req_end_x = '0, req_end_y = '0;
   logic csr_write_enable = 1'b0;
   logic [bcf_pkg::SEG_BITS-1:0] csr_write_data = '0;
   logic rsp_valid;
   logic [bcf_pkg::OUT_BITS-1:0] rsp_vertex_x, rsp_vertex_y;
   logic rsp_last_vertex, rsp_count_clamped;

   typedef struct packed {
      logic [11:0] x;
      logic [11:0] y;
      logic        last;
      logic        clamped;
   } vertex_type;

   vertex_type vertex_q[$];
   logic [11:0] seg_len_model = 12'd4;
   int mismatches = 0;
   bit quiet_sender = 0;

   bezier_curve_flattener dut (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_degree(req_degree),
      .req_start_x(req_start_x), .req_start_y(req_start_y),
      .req_ctrl_a_x(req_ctrl_a_x), .req_ctrl_a_y(req_ctrl_a_y),
      .req_ctrl_b_x(req_ctrl_b_x), .req_ctrl_b_y(req_ctrl_b_y),
      .req_end_x(req_end_x), .req_end_y(req_end_y),
      .csr_write_enable(csr_write_enable), .csr_write_data(csr_write_data),
      .rsp_valid(rsp_valid), .rsp_vertex_x(rsp_vertex_x), .rsp_vertex_y(rsp_vertex_y),
      .rsp_last_vertex(rsp_last_vertex), .rsp_count_clamped(rsp_count_clamped)
   );

   always #5 clock = ~clock;

   initial begin
      #50_000_000;
      $display("*** FAILED ***");
      $finish;
   end

   // floor(sqrt(v)), bit by bit
   function automatic longint unsigned isqrt(input longint unsigned v);
      longint unsigned root, bitv;
      root = 0;
      bitv = 64'd1 << 62;
      while (bitv > v) bitv >>= 2;
      while (bitv != 0) begin
         if (v >= root + bitv) begin
            v -= root + bitv;
            root = (root >> 1) + bitv;
         end else begin
            root >>= 1;
         end
         bitv >>= 2;
      end
      return root;
   endfunction

   function automatic longint unsigned leg_len_q8(input longint unsigned ax, ay, bx, by);
      longint unsigned dx, dy;
      dx = ax > bx ? ax - bx : bx - ax;
      dy = ay > by ? ay - by : by - ay;
      return isqrt((dx * dx + dy * dy) << 16);
   endfunction

   // expected vertices of one curve
   task automatic predict_vertices(input logic cubic, input logic [11:0] p[8]);
      longint unsigned px[4], py[4], len, seg, n, u, w0, w1, w2, w3, den, vx, vy;
      bit clamped;
      vertex_type v;
      clamped = 0;
      for (int i = 0; i < 4; i++) begin
         px[i] = p[2*i];
         py[i] = p[2*i+1];
      end
      if (!cubic) begin
         px[2] = px[3];
         py[2] = py[3];
      end
      len = leg_len_q8(px[0], py[0], px[1], py[1]) + leg_len_q8(px[1], py[1], px[2], py[2]);
      if (cubic) len += leg_len_q8(px[2], py[2], px[3], py[3]);
      seg = (seg_len_model == 0) ? 1 : seg_len_model;
      n = len / (seg << 8);
      if (n < 1) begin
         n = 1;
         clamped = 1;
      end else if (n > MAX_SEG) begin
         n = MAX_SEG;
         clamped = 1;
      end
      for (longint unsigned k = 0; k <= n; k++) begin
         u = n - k;
         if (cubic) begin
            w0 = u*u*u; w1 = 3*k*u*u; w2 = 3*k*k*u; w3 = k*k*k; den = n*n*n;
            vx = (px[0]*w0 + px[1]*w1 + px[2]*w2 + px[3]*w3) / den;
            vy = (py[0]*w0 + py[1]*w1 + py[2]*w2 + py[3]*w3) / den;
         end else begin
            w0 = u*u; w1 = 2*k*u; w2 = k*k; den = n*n;
            vx = (px[0]*w0 + px[1]*w1 + px[2]*w2) / den;
            vy = (py[0]*w0 + py[1]*w1 + py[2]*w2) / den;
         end
         v.x = vx[11:0];
         v.y = vy[11:0];
         v.last = (k == n);
         v.clamped = clamped;
         vertex_q.push_back(v);
      end
   endtask

   // send one curve beat; random idle before it unless quiet_sender is set, start held until the next idle or drain
   task automatic send_curve(input logic cubic, input logic [11:0] p[8]);
      if (!quiet_sender)
         while ($urandom_range(99) < 34) begin
            start <= 1'b0;
            @(posedge clock);
         end
      start        <= 1'b1;
      req_degree   <= cubic;
      req_start_x  <= p[0]; req_start_y  <= p[1];
      req_ctrl_a_x <= p[2]; req_ctrl_a_y <= p[3];
      req_ctrl_b_x <= p[4]; req_ctrl_b_y <= p[5];
      req_end_x    <= p[6]; req_end_y    <= p[7];
      @(posedge clock);
      while (busy) @(posedge clock);
      predict_vertices(cubic, p);
   endtask

   task automatic drain();
      start <= 1'b0;
      while (vertex_q.size() != 0) @(posedge clock);
      repeat (SETTLE_CYC) @(posedge clock);
   endtask

   task automatic write_seg_len(input logic [11:0] val);
      drain();
      csr_write_enable <= 1'b1;
      csr_write_data   <= val;
      @(posedge clock);
      csr_write_enable <= 1'b0;
      seg_len_model = val;
   endtask

   // check each vertex beat against the oldest expectation
   always @(posedge clock) begin
      if (!reset && rsp_valid) begin
         vertex_type exp_v;
         if (vertex_q.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected vertex beat x=%0d y=%0d",
               rsp_vertex_x, rsp_vertex_y);
         end else begin
            exp_v = vertex_q.pop_front();
            if (rsp_vertex_x !== exp_v.x || rsp_vertex_y !== exp_v.y ||
                rsp_last_vertex !== exp_v.last || rsp_count_clamped !== exp_v.clamped) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("vertex mismatch: exp x=%0d y=%0d last=%0b clamp=%0b, ",
                     exp_v.x, exp_v.y, exp_v.last, exp_v.clamped,
                     "got x=%0d y=%0d last=%0b clamp=%0b",
                     rsp_vertex_x, rsp_vertex_y, rsp_last_vertex, rsp_count_clamped);
            end
         end
      end
   end

   function automatic logic [11:0] rand_coord();
      case ($urandom_range(5))
         0: return 12'd0;
         1: return 12'hFFF;
         2: return 12'($urandom_range(63));
         default: return 12'($urandom);
      endcase
   endfunction

   task automatic test_directed();
      logic [11:0] p[8];
      // degenerate point curve: count too small
      p = '{default: 12'd0};
      send_curve(1'b0, p);
      send_curve(1'b1, p);
      p = '{default: 12'hFFF};
      send_curve(1'b1, p);
      // long diagonal: count too large
      p = '{12'd0, 12'd0, 12'hFFF, 12'hFFF, 12'd0, 12'd0, 12'hFFF, 12'hFFF};
      send_curve(1'b1, p);
      send_curve(1'b0, p);
      p = '{12'hFFF, 12'd0, 12'd0, 12'hFFF, 12'hFFF, 12'hFFF, 12'd0, 12'd0};
      send_curve(1'b0, p);
      send_curve(1'b1, p);
      // mid-size curves; only the first quadratic stays unclamped
      p = '{12'd10, 12'd20, 12'd40, 12'd60, 12'd80, 12'd30, 12'd100, 12'd100};
      send_curve(1'b0, p);
      send_curve(1'b1, p);
      p = '{12'hAAA, 12'h555, 12'hA80, 12'h560, 12'hAC0, 12'h540, 12'hAF0, 12'h5A0};
      send_curve(1'b1, p);
      send_curve(1'b0, p);
   endtask

   task automatic test_seg_len_zero();
      logic [11:0] p[8];
      write_seg_len(12'd0);
      p = '{12'd0, 12'd0, 12'd5, 12'd3, 12'd9, 12'd9, 12'd12, 12'd4};
      send_curve(1'b1, p);
      send_curve(1'b0, p);
      write_seg_len(12'd1);
      send_curve(1'b1, p);
      write_seg_len(12'hFFF);
      p = '{12'd0, 12'd0, 12'hFFF, 12'hFFF, 12'd0, 12'hFFF, 12'hFFF, 12'd0};
      send_curve(1'b1, p);
   endtask

   task automatic run_random(input int count);
      logic [11:0] p[8];
      for (int i = 0; i < count; i++) begin
         foreach (p[j]) p[j] = rand_coord();
         send_curve(1'($urandom), p);
      end
   endtask

   task automatic test_random_settings();
      logic [11:0] lens[6] = '{12'd4, 12'd1, 12'd64, 12'd4095, 12'd0, 12'd200};
      foreach (lens[i]) begin
         write_seg_len(lens[i]);
         run_random(40);
      end
      // no sender idling for a stretch
      quiet_sender = 1;
      write_seg_len(12'($urandom_range(1, 500)));
      run_random(40);
      quiet_sender = 0;
      // pause until everything has drained, then go on
      drain();
      run_random(20);
   endtask

   initial begin
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed();
      test_seg_len_zero();
      test_random_settings();
      drain();
      if (mismatches == 0 && vertex_q.size() == 0)
         $display("*** PASSED ***");
      else
         $display("*** FAILED ***");
      $finish;
   end

endmodule
